// ===== hw/rtl/cde_pkg.sv =====
// ----------------------------------------------------------------------------
// cde_pkg
// Shared types and fixed widths for the circular double-ended queue.
// ----------------------------------------------------------------------------
package cde_pkg;

    localparam int FUNC_W      = 2;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 4;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_REAR  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_REAR   = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    // Per-cell update controls, at most one set per cycle
    typedef struct packed {
        logic from_lower;   // take the word of the cell nearer the front
        logic from_upper;   // take the word of the cell nearer the rear
        logic load;         // take the pushed word
    } t_cell_ctl;

endpackage

// ===== hw/rtl/cde_cell.sv =====
// ----------------------------------------------------------------------------
// cde_cell
// One entry of the shifting deque row: holds a word, shifts toward either
// neighbor, loads a pushed word, and offers its word when it is the rear.
// ----------------------------------------------------------------------------
module cde_cell #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  cde_pkg::t_cell_ctl  i_ctl,
    input  logic [W-1:0]        i_word,
    input  logic [W-1:0]        i_lower,
    input  logic [W-1:0]        i_upper,
    input  logic                i_rear_sel,
    output logic [W-1:0]        o_data,
    output logic [W-1:0]        o_tap
);

    logic [W-1:0] r_data;
    logic [W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_word;
        end else if (i_ctl.from_lower) begin
            n_data = i_lower;
        end else if (i_ctl.from_upper) begin
            n_data = i_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Gate so the top can OR all taps into the rear word
    assign o_tap  = i_rear_sel ? r_data : '0;

endmodule

// ===== hw/rtl/circular_deque_top.sv =====
// ----------------------------------------------------------------------------
// circular_deque_top
// Fixed-depth double-ended queue built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Each input word is one operation (push front, push rear, pop front, pop
// rear) and gives exactly one result word in the next cycle: the popped value,
// a status and the occupancy after the operation. The entries sit in a row
// of DEPTH cells ordered front first; a push or pop at the front shifts the
// whole row by one cell, a push at the rear loads the cell just past the last
// entry and a pop at the rear reads that last entry, so a new operation is
// taken every cycle as long as the result side keeps taking words. Pushes
// to a full queue and pops from an empty queue are refused and flagged, and
// leave the contents as they were.
// ----------------------------------------------------------------------------
module circular_deque_top #(
    parameter int DEPTH      = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cde_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] push_value
    input  logic [cde_pkg::S_TUSER_W-1:0]  s_tuser,   // [1:0] func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cde_pkg::M_TDATA_W-1:0]  m_tdata    // [31:0] pop_value,
                                                      // [33:32] status,
                                                      // [37:34] occupancy
);

    localparam int VW     = cde_pkg::VALUE_W;
    localparam int OW     = cde_pkg::OCC_W;
    localparam int CELL_W = (DATA_WIDTH < VW) ? DATA_WIDTH : VW;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PAD_W  = cde_pkg::M_TDATA_W - VW - cde_pkg::STATUS_W - OW;

    logic                  w_accept;
    cde_pkg::t_func        w_func;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_is_push;
    logic                  w_ok;
    logic                  w_do;
    logic [CELL_W-1:0]     w_word;
    logic [CELL_W-1:0]     w_rear;
    logic [CELL_W-1:0]     w_pop_word;
    cde_pkg::t_status      w_status;

    logic [CELL_W-1:0]     w_data [DEPTH];
    logic [CELL_W-1:0]     w_tap  [DEPTH];
    cde_pkg::t_cell_ctl    w_ctl  [DEPTH];

    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic                  r_m_valid;
    logic [VW-1:0]         r_pop_value;
    cde_pkg::t_status      r_status;
    logic [OW-1:0]         r_occ;

    assign s_tready  = !r_m_valid || m_tready;
    assign w_accept  = s_tvalid && s_tready;
    assign w_func    = cde_pkg::t_func'(s_tuser);
    assign w_word    = CELL_W'(s_tdata[VW-1:0]);
    assign w_full    = (r_cnt == CNT_W'(DEPTH));
    assign w_empty   = (r_cnt == '0);
    assign w_is_push = (w_func == cde_pkg::FUNC_PUSH_FRONT) ||
                       (w_func == cde_pkg::FUNC_PUSH_REAR);
    assign w_ok      = w_is_push ? !w_full : !w_empty;
    assign w_do      = w_accept && w_ok;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [CELL_W-1:0] w_lower;
            logic [CELL_W-1:0] w_upper;

            if (gi == 0) begin : g_first
                assign w_lower = w_word;
            end else begin : g_mid_lo
                assign w_lower = w_data[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign w_upper = w_data[gi];
            end else begin : g_mid_hi
                assign w_upper = w_data[gi+1];
            end

            assign w_ctl[gi].from_lower = w_do && (w_func == cde_pkg::FUNC_PUSH_FRONT);
            assign w_ctl[gi].from_upper = w_do && (w_func == cde_pkg::FUNC_POP_FRONT);
            assign w_ctl[gi].load       = w_do && (w_func == cde_pkg::FUNC_PUSH_REAR) &&
                                          (r_cnt == CNT_W'(gi));

            cde_cell #(
                .W (CELL_W)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[gi]),
                .i_word     (w_word),
                .i_lower    (w_lower),
                .i_upper    (w_upper),
                .i_rear_sel (r_cnt == CNT_W'(gi + 1)),
                .o_data     (w_data[gi]),
                .o_tap      (w_tap[gi])
            );
        end
    endgenerate

    // Only the last stored cell drives its tap
    always_comb begin
        w_rear = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rear = w_rear | w_tap[i];
        end
    end

    always_comb begin
        w_pop_word = '0;
        w_status   = cde_pkg::STATUS_OK;
        n_cnt      = r_cnt;
        case (w_func)
            cde_pkg::FUNC_PUSH_FRONT,
            cde_pkg::FUNC_PUSH_REAR: begin
                if (w_full) begin
                    w_status = cde_pkg::STATUS_FULL;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            cde_pkg::FUNC_POP_FRONT: begin
                if (w_empty) begin
                    w_status = cde_pkg::STATUS_EMPTY;
                end else begin
                    w_pop_word = w_data[0];
                    n_cnt      = r_cnt - CNT_W'(1);
                end
            end
            cde_pkg::FUNC_POP_REAR: begin
                if (w_empty) begin
                    w_status = cde_pkg::STATUS_EMPTY;
                end else begin
                    w_pop_word = w_rear;
                    n_cnt      = r_cnt - CNT_W'(1);
                end
            end
            default: begin
                w_status = cde_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_cnt     <= n_cnt;
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Hold the result word until it is taken
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pop_value <= VW'(w_pop_word);
            r_status    <= w_status;
            r_occ       <= OW'(n_cnt);
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {{PAD_W{1'b0}}, r_occ, r_status, r_pop_value};

endmodule

// ===== hw/rtl/cde_checker.sv =====
// ----------------------------------------------------------------------------
// cde_checker
// Port-level checks on the deque's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module cde_checker #(
    parameter int DEPTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [cde_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int OW = cde_pkg::OCC_W;

    logic [cde_pkg::STATUS_W-1:0] w_status;
    logic [OW-1:0]                w_occ;
    logic [OW-1:0]                w_depth_occ;

    assign w_status    = m_tdata[33:32];
    assign w_occ       = m_tdata[37:34];
    assign w_depth_occ = OW'(DEPTH);

    // Every accepted operation shows its result on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted operation produced no result word");

    // A stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // A refused operation returns no data
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (w_status != cde_pkg::STATUS_OK) |-> (m_tdata[31:0] == '0))
        else $error("refused operation returned data");

    // Refusals agree with the reported occupancy
    a_refused_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |->
            ((w_status != cde_pkg::STATUS_EMPTY) || (w_occ == '0)) &&
            ((w_status != cde_pkg::STATUS_FULL) || (w_occ == w_depth_occ)))
        else $error("refusal status disagrees with occupancy");

endmodule

bind circular_deque_top cde_checker #(.DEPTH(DEPTH)) u_cde_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the circular double-ended queue.
// ----------------------------------------------------------------------------
// Operations stream in on the slave side and results stream out on the
// master side. A predictor in the bench tracks the queue contents and works
// out the popped word, status and fill level for every accepted operation.
// The monitor compares each result against the oldest prediction. The run
// covers a directed sequence of edge cases, then random bursts that swing
// the queue between empty and full, under several idle and stall patterns.
// It also includes one long output hold that backs the block up.
// ----------------------------------------------------------------------------
module testbench;

    localparam int QDEPTH      = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;

    typedef struct {
        cde_pkg::t_func  op;
        logic [31:0]     word;
    } t_deque_op;

    typedef struct {
        logic [31:0]      pop_value;
        cde_pkg::t_status status;
        logic [3:0]       occupancy;
    } t_deque_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [cde_pkg::S_TDATA_W-1:0]  s_tdata;    // [31:0] push_value
    logic [cde_pkg::S_TUSER_W-1:0]  s_tuser;    // [1:0] func
    logic                           m_tvalid;
    logic                           m_tready;
    logic [cde_pkg::M_TDATA_W-1:0]  m_tdata;    // [31:0] pop_value, [33:32] status,
                                                // [37:34] occupancy

    t_deque_op      pending_ops[$];
    t_deque_result  awaited_results[$];

    // Predictor state
    logic [31:0]    slot_words[QDEPTH];
    int             front_slot;
    int             back_slot;
    int             fill_level;

    int             sender_idle_pct;
    int             receiver_stall_pct;
    int             hold_requests;
    int             hold_served;
    int             hold_left;
    logic           in_taken;

    int             ops_queued;
    int             ops_accepted;
    int             results_checked;
    int             full_refusals;
    int             empty_refusals;
    int             error_count;
    int             cycle_count;

    circular_deque_top #(
        .DEPTH      (QDEPTH),
        .DATA_WIDTH (32)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        error_count++;
    endtask

    // Apply one operation to the tracked queue and return its result.
    function automatic t_deque_result predict_deque_op(cde_pkg::t_func op,
                                                       logic [31:0] word);
        t_deque_result r;
        r.pop_value = '0;
        r.status    = cde_pkg::STATUS_OK;
        case (op)
            cde_pkg::FUNC_PUSH_FRONT, cde_pkg::FUNC_PUSH_REAR: begin
                if (fill_level >= QDEPTH) begin
                    r.status = cde_pkg::STATUS_FULL;
                end else if (op == cde_pkg::FUNC_PUSH_FRONT) begin
                    front_slot = (front_slot + QDEPTH - 1) % QDEPTH;
                    slot_words[front_slot] = word;
                    fill_level++;
                end else begin
                    slot_words[back_slot] = word;
                    back_slot = (back_slot + 1) % QDEPTH;
                    fill_level++;
                end
            end
            default: begin
                if (fill_level == 0) begin
                    r.status = cde_pkg::STATUS_EMPTY;
                end else if (op == cde_pkg::FUNC_POP_FRONT) begin
                    r.pop_value = slot_words[front_slot];
                    front_slot = (front_slot + 1) % QDEPTH;
                    fill_level--;
                end else begin
                    back_slot = (back_slot + QDEPTH - 1) % QDEPTH;
                    r.pop_value = slot_words[back_slot];
                    fill_level--;
                end
            end
        endcase
        r.occupancy = 4'(fill_level);
        return r;
    endfunction

    task automatic add_op(cde_pkg::t_func op, logic [31:0] word);
        t_deque_op item;
        item.op   = op;
        item.word = word;
        pending_ops.push_back(item);
        ops_queued++;
    endtask

    // Random bursts that lean toward pushes or pops, or stay balanced, so the queue keeps
    // hitting both the full and the empty boundary.
    task automatic add_random_ops(int count);
        int          lean;
        int          push_pct;
        logic [31:0] word;
        lean = 0;
        for (int i = 0; i < count; i++) begin
            if (i % 16 == 0)
                lean = $urandom_range(0, 2);
            push_pct = (lean == 0) ? 85 : (lean == 1) ? 15 : 50;
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0: word = 32'h8000_0000;
                    1: word = 32'h7fff_ffff;
                    2: word = 32'h0000_0000;
                    default: word = 32'hffff_ffff;
                endcase
            end else begin
                word = $urandom;
            end
            if ($urandom_range(0, 99) < push_pct)
                add_op($urandom_range(0, 1) ? cde_pkg::FUNC_PUSH_REAR
                                            : cde_pkg::FUNC_PUSH_FRONT, word);
            else
                add_op($urandom_range(0, 1) ? cde_pkg::FUNC_POP_REAR
                                            : cde_pkg::FUNC_POP_FRONT, word);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (ops_accepted != ops_queued || awaited_results.size() != 0);
    endtask

    // Sender: hold an offered word until it is taken.
    always @(negedge i_clk) begin
        t_deque_op item;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                item = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= item.word;
                s_tuser  <= item.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long output hold, started on request.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    always @(negedge i_clk) begin
        m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Check results first, then predict for the word taken at the same edge.
    always @(posedge i_clk) begin
        t_deque_result want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[31:0], '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata[31:0] !== want.pop_value)
                        report_mismatch("pop_value", m_tdata[31:0], want.pop_value);
                    if (m_tdata[33:32] !== want.status)
                        report_mismatch("status", 32'(m_tdata[33:32]), 32'(want.status));
                    if (m_tdata[37:34] !== want.occupancy)
                        report_mismatch("occupancy", 32'(m_tdata[37:34]),
                                        32'(want.occupancy));
                    results_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                want = predict_deque_op(cde_pkg::t_func'(s_tuser), s_tdata);
                if (want.status == cde_pkg::STATUS_FULL)
                    full_refusals++;
                if (want.status == cde_pkg::STATUS_EMPTY)
                    empty_refusals++;
                awaited_results.push_back(want);
                ops_accepted++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tuser            = '0;
        m_tready           = 1'b0;
        in_taken           = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_requests      = 0;
        hold_served        = 0;
        hold_left          = 0;
        front_slot         = 0;
        back_slot          = 0;
        fill_level         = 0;
        ops_queued         = 0;
        ops_accepted       = 0;
        results_checked    = 0;
        full_refusals      = 0;
        empty_refusals     = 0;
        error_count        = 0;
        cycle_count        = 0;
        foreach (slot_words[i])
            slot_words[i] = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pops, fill with extremes from both ends, full
        // pushes, drain from both ends, and last-entry pops from each side.
        add_op(cde_pkg::FUNC_POP_FRONT,  32'hdead_beef);
        add_op(cde_pkg::FUNC_POP_REAR,   32'h0000_0000);
        add_op(cde_pkg::FUNC_PUSH_FRONT, 32'h7fff_ffff);
        add_op(cde_pkg::FUNC_PUSH_REAR,  32'h8000_0000);
        add_op(cde_pkg::FUNC_PUSH_FRONT, 32'h0000_0000);
        add_op(cde_pkg::FUNC_PUSH_REAR,  32'hffff_ffff);
        add_op(cde_pkg::FUNC_PUSH_FRONT, 32'h0000_0001);
        add_op(cde_pkg::FUNC_PUSH_REAR,  32'h5555_5555);
        add_op(cde_pkg::FUNC_PUSH_FRONT, 32'haaaa_aaaa);
        add_op(cde_pkg::FUNC_PUSH_REAR,  32'h1234_5678);
        add_op(cde_pkg::FUNC_PUSH_FRONT, 32'hcafe_f00d);
        add_op(cde_pkg::FUNC_PUSH_REAR,  32'h0bad_0bad);
        for (int i = 0; i < 4; i++) begin
            add_op(cde_pkg::FUNC_POP_FRONT, $urandom);
            add_op(cde_pkg::FUNC_POP_REAR,  $urandom);
        end
        add_op(cde_pkg::FUNC_POP_FRONT,  32'hffff_ffff);
        add_op(cde_pkg::FUNC_PUSH_REAR,  32'h0f0f_0f0f);
        add_op(cde_pkg::FUNC_POP_FRONT,  32'h0000_0000);
        add_op(cde_pkg::FUNC_PUSH_FRONT, 32'hf0f0_f0f0);
        add_op(cde_pkg::FUNC_POP_REAR,   32'h0000_0000);
        add_op_random_phase: begin
            add_random_ops(320);
        end
        wait_drained();

        @(posedge i_clk);
        sender_idle_pct = 82;
        add_random_ops(330);
        wait_drained();

        @(posedge i_clk);
        sender_idle_pct    = 0;
        receiver_stall_pct = 82;
        add_random_ops(330);
        wait_drained();

        @(posedge i_clk);
        sender_idle_pct    = 33;
        receiver_stall_pct = 33;
        add_random_ops(330);
        wait_drained();

        // Hold the output side off while words keep coming in.
        @(posedge i_clk);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_requests      = hold_requests + 1;
        add_random_ops(90);
        wait_drained();

        repeat (20) @(negedge i_clk);

        $display("ran %0d deque operations, %0d results checked", ops_accepted,
                 results_checked);
        $display("boundary hits: %0d pushes refused full, %0d pops refused empty",
                 full_refusals, empty_refusals);
        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d errors, %0d results outstanding", error_count,
                     awaited_results.size());
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
